// ===== hw/rtl/hc_pkg.sv =====
// ----------------------------------------------------------------------------
// hc_pkg: shared types, constants and functions
// alphabet mapping, key register indexes and modulo-31 reduction
// ----------------------------------------------------------------------------
package hc_pkg;

  localparam int unsigned SymW     = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyW     = 5;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned SumW     = 11;  // 31*31 + 31*31 fits
  localparam int unsigned QueueDepth = 2;

  typedef logic [SymW-1:0]     sym_t;
  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [KeyW-1:0]     key_t;
  typedef logic [SumW-1:0]     sum_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef struct packed {
    sym_t p0;
    sym_t p1;
  } pair_t;

  // register indexes
  localparam cfg_idx_t RegKeyR0C0 = CfgIdxW'(0);
  localparam cfg_idx_t RegKeyR0C1 = CfgIdxW'(1);
  localparam cfg_idx_t RegKeyR1C0 = CfgIdxW'(2);
  localparam cfg_idx_t RegKeyR1C1 = CfgIdxW'(3);

  // key reset values (identity matrix)
  localparam key_t KeyR0C0Rst = KeyW'(1);
  localparam key_t KeyR0C1Rst = KeyW'(0);
  localparam key_t KeyR1C0Rst = KeyW'(0);
  localparam key_t KeyR1C1Rst = KeyW'(1);

  // character codes
  localparam byte_t CharLowA     = 8'h61;
  localparam byte_t CharLowZ     = 8'h7a;
  localparam byte_t CharUpA      = 8'h41;
  localparam byte_t CharUpZ      = 8'h5a;
  localparam byte_t CharSpace    = 8'h20;
  localparam byte_t CharComma    = 8'h2c;
  localparam byte_t CharPeriod   = 8'h2e;
  localparam byte_t CharQuestion = 8'h3f;
  localparam byte_t CharColon    = 8'h3a;

  // symbol codes: letter bounds and the codes past the letters
  localparam sym_t SymLetterA = SymW'(0);
  localparam sym_t SymLetterZ = SymW'(25);
  localparam sym_t SymSpace    = SymW'(26);
  localparam sym_t SymComma    = SymW'(27);
  localparam sym_t SymPeriod   = SymW'(28);
  localparam sym_t SymQuestion = SymW'(29);
  localparam sym_t SymColon    = SymW'(30);
  localparam sym_t SymModulus  = SymW'(31);

  function automatic sym_t byte_to_sym(byte_t b);
    sym_t s;
    s = SymLetterA;
    if (b inside {[CharUpA:CharUpZ]}) begin
      s = SymW'(b - CharUpA);
    end else if (b inside {[CharLowA:CharLowZ]}) begin
      s = SymW'(b - CharLowA);
    end else begin
      case (b)
        CharSpace:    s = SymSpace;
        CharComma:    s = SymComma;
        CharPeriod:   s = SymPeriod;
        CharQuestion: s = SymQuestion;
        CharColon:    s = SymColon;
        default:      s = SymLetterA;
      endcase
    end
    return s;
  endfunction

  function automatic byte_t sym_to_byte(sym_t s);
    byte_t b;
    if (s <= SymLetterZ) begin
      b = CharLowA + ByteW'(s);
    end else begin
      case (s)
        SymSpace:    b = CharSpace;
        SymComma:    b = CharComma;
        SymPeriod:   b = CharPeriod;
        SymQuestion: b = CharQuestion;
        SymColon:    b = CharColon;
        default:     b = CharLowA;
      endcase
    end
    return b;
  endfunction

  // 2^5 = 1 mod 31, so fold the high bits onto the low bits twice
  function automatic sym_t mod31(sum_t x);
    logic [6:0] fold1;
    logic [5:0] fold2;
    sym_t       r;
    fold1 = 7'(x[SumW-1:SymW]) + 7'(x[SymW-1:0]);
    fold2 = 6'(fold1[6:5]) + 6'(fold1[4:0]);
    if (fold2 >= 6'(SymModulus)) begin
      r = SymW'(fold2 - 6'(SymModulus));
    end else begin
      r = SymW'(fold2);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hc_if.sv =====
// ----------------------------------------------------------------------------
// hc_if: stream and configuration channels
// text byte in, cipher character out, key register write
// ----------------------------------------------------------------------------
interface hc_text_if;
  logic          valid;
  logic          ready;
  hc_pkg::byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface hc_cipher_if;
  logic          valid;
  logic          ready;
  hc_pkg::byte_t cipher_byte;
  logic          pair_last;

  modport source (output valid, output cipher_byte, output pair_last, input ready);
  modport sink   (input valid, input cipher_byte, input pair_last, output ready);
endinterface

interface hc_cfg_if;
  logic              valid;
  logic              ready;
  hc_pkg::cfg_idx_t  index;
  hc_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/hill_cipher_2x2_mod31_stream.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod31_stream: streaming 2x2 hill cipher over 31 symbols
// text bytes in, cipher characters out in pairs, key set by register writes
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                         transfer when
//  text_i    in   text_byte[7:0]                  valid && ready
//  cipher_o  out  cipher_byte[7:0], pair_last     valid && ready
//  cfg_i     in   index[7:0], data[7:0] (4:0)     valid && ready (ready tied high)
//
//  one byte per cycle sustained while the output is not stalled; the output
//  port moves one character per cycle, two per pair, which matches two input
//  bytes per pair; a pair passes the queue, sum and output registers in order
//  reset: identity key, no symbol held, pair queue and output stages empty
//  an output stall fills the output and sum stages, then QueueDepth pairs in
//  the queue; after that the second byte of a pair waits, a first byte is
//  still taken
//
module hill_cipher_2x2_mod31_stream #(
  parameter int unsigned QueueDepth = hc_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hc_text_if.sink     text_i,
  hc_cipher_if.source cipher_o,
  hc_cfg_if.sink      cfg_i
);
  import hc_pkg::*;

  // front to queue
  logic  fr_valid, fr_ready;
  pair_t fr_pair;
  // queue to back
  logic  bk_valid, bk_ready;
  pair_t bk_pair;

  // front: classify each byte, hold the first symbol, push complete pairs
  hc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .pair_valid_o (fr_valid),
    .pair_o       (fr_pair),
    .pair_ready_i (fr_ready)
  );

  // short queue so either side can stall on its own
  hc_pair_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_pair_i   (fr_pair),
    .in_ready_o  (fr_ready),
    .out_valid_o (bk_valid),
    .out_pair_o  (bk_pair),
    .out_ready_i (bk_ready)
  );

  // back: row sums, modulo 31, alphabet lookup, two characters per pair
  hc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .pair_valid_i (bk_valid),
    .pair_i       (bk_pair),
    .pair_ready_o (bk_ready),
    .cipher_o     (cipher_o)
  );

endmodule

// ===== hw/rtl/hc_front.sv =====
// ----------------------------------------------------------------------------
// hc_front: byte classification and pairing
// maps each byte to a symbol, holds the first of a pair, pushes full pairs
// ----------------------------------------------------------------------------
module hc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  hc_text_if.sink       text_i,
  output logic          pair_valid_o,
  output hc_pkg::pair_t pair_o,
  input  logic          pair_ready_i
);
  import hc_pkg::*;

  logic have_first_q, have_first_d;
  sym_t held_q, held_d;
  sym_t sym;
  logic text_fire;

  assign sym = byte_to_sym(text_i.text_byte);

  // a first byte never needs queue space
  assign text_i.ready = !have_first_q || pair_ready_i;
  assign text_fire    = text_i.valid && text_i.ready;

  assign pair_valid_o = text_i.valid && have_first_q;
  assign pair_o.p0    = held_q;
  assign pair_o.p1    = sym;

  always_comb begin
    have_first_d = have_first_q;
    held_d       = held_q;
    if (text_fire) begin
      have_first_d = !have_first_q;
      if (!have_first_q) begin
        held_d = sym;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      held_q       <= '0;
    end else begin
      have_first_q <= have_first_d;
      held_q       <= held_d;
    end
  end

endmodule

// ===== hw/rtl/hc_pair_fifo.sv =====
// ----------------------------------------------------------------------------
// hc_pair_fifo: short symbol-pair queue
// register-based fifo between the front and back parts
// ----------------------------------------------------------------------------
module hc_pair_fifo #(
  parameter int unsigned Depth = hc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  hc_pkg::pair_t in_pair_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output hc_pkg::pair_t out_pair_o,
  input  logic          out_ready_i
);
  import hc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pair_t            entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != CntW'(Depth));
  assign out_valid_o = (count_q != '0);
  assign out_pair_o  = entries_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_pair_i;
    end
  end

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("pair queue count did not follow a push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == CntW'($past(count_q) - 1'b1))
    else $error("pair queue count did not follow a pop");

endmodule

// ===== hw/rtl/hc_back.sv =====
// ----------------------------------------------------------------------------
// hc_back: key matrix product and character output
// holds the key, forms both row sums, reduces, emits two characters a pair
// ----------------------------------------------------------------------------
module hc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  hc_cfg_if.sink        cfg_i,
  input  logic          pair_valid_i,
  input  hc_pkg::pair_t pair_i,
  output logic          pair_ready_o,
  hc_cipher_if.source   cipher_o
);
  import hc_pkg::*;

  key_t k00_q, k00_d, k01_q, k01_d, k10_q, k10_d, k11_q, k11_d;

  logic  s1_valid_q, s1_valid_d;
  sum_t  sum0_q, sum1_q;
  logic  out_valid_q, out_valid_d;
  logic  phase_q, phase_d;
  byte_t byte0_q, byte1_q;

  logic  cfg_fire, pair_fire, out_fire, s2_free, load;

  // key registers
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_comb begin
    k00_d = k00_q;
    k01_d = k01_q;
    k10_d = k10_q;
    k11_d = k11_q;
    if (cfg_fire) begin
      case (cfg_i.index)
        RegKeyR0C0: k00_d = cfg_i.data[KeyW-1:0];
        RegKeyR0C1: k01_d = cfg_i.data[KeyW-1:0];
        RegKeyR1C0: k10_d = cfg_i.data[KeyW-1:0];
        RegKeyR1C1: k11_d = cfg_i.data[KeyW-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_fire     = cipher_o.valid && cipher_o.ready;
  assign s2_free      = !out_valid_q || (out_fire && phase_q);
  assign load         = s1_valid_q && s2_free;
  assign pair_ready_o = !s1_valid_q || load;
  assign pair_fire    = pair_valid_i && pair_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pair_fire) begin
      s1_valid_d = 1'b1;
    end else if (load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    phase_d     = phase_q;
    if (load) begin
      out_valid_d = 1'b1;
      phase_d     = 1'b0;
    end else if (out_fire) begin
      out_valid_d = !phase_q ? 1'b1 : 1'b0;
      phase_d     = !phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k00_q       <= KeyR0C0Rst;
      k01_q       <= KeyR0C1Rst;
      k10_q       <= KeyR1C0Rst;
      k11_q       <= KeyR1C1Rst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      k00_q       <= k00_d;
      k01_q       <= k01_d;
      k10_q       <= k10_d;
      k11_q       <= k11_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  // row sums, then reduction and character lookup
  always_ff @(posedge clk_i) begin
    if (pair_fire) begin
      sum0_q <= SumW'(k00_q) * SumW'(pair_i.p0) + SumW'(k01_q) * SumW'(pair_i.p1);
      sum1_q <= SumW'(k10_q) * SumW'(pair_i.p0) + SumW'(k11_q) * SumW'(pair_i.p1);
    end
    if (load) begin
      byte0_q <= sym_to_byte(mod31(sum0_q));
      byte1_q <= sym_to_byte(mod31(sum1_q));
    end
  end

  assign cipher_o.valid       = out_valid_q;
  assign cipher_o.cipher_byte = phase_q ? byte1_q : byte0_q;
  assign cipher_o.pair_last   = phase_q;

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !phase_q |=> out_valid_q && phase_q)
    else $error("second character of a pair not presented");

  a_drop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(phase_q) && $past(out_fire))
    else $error("output dropped before the pair was delivered");

endmodule

// ===== test/hill_cipher_2x2_mod31_stream_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hill_cipher_2x2_mod31_stream_tb: self-checking bench for the hill cipher
// drives text bytes and key register writes, predicts every cipher character
// with an independent model of the 2x2 mod-31 cipher and checks each transfer
// ---------------------------------------------------------------------------
module hill_cipher_2x2_mod31_stream_tb;
  import hc_pkg::*;

  localparam int       ClkPeriodNs    = 12;
  localparam int       ResetCycles    = 8;
  // output lags the second byte of a pair through the queue, sum and output registers
  localparam int       DrainCycles    = 12;
  localparam int       EndWaitCycles  = 5000;
  localparam int       ReportLimit    = 40;
  localparam int       AlphabetSize   = int'(SymModulus);
  localparam int       RandomPhases   = 8;
  localparam int       PhaseBytes     = 118;  // even, so no symbol is held across a key change
  localparam cfg_idx_t RegFirstUnused = CfgIdxW'(4);
  localparam cfg_idx_t RegLastUnused  = CfgIdxW'(255);

  typedef struct packed {
    byte_t cipher_byte;
    logic  pair_last;
  } cipher_char_t;

  logic clk;
  logic rst_n;

  hc_text_if   text_ch ();
  hc_cipher_if cipher_ch ();
  hc_cfg_if    cfg_ch ();

  hill_cipher_2x2_mod31_stream u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .text_i   (text_ch),
    .cipher_o (cipher_ch),
    .cfg_i    (cfg_ch)
  );

  // cipher model state: key matrix, held first symbol of a pair
  key_t         key_mat [4];
  sym_t         held_sym;
  bit           holding;
  byte_t        alphabet [AlphabetSize];
  sym_t         sym_of [256];
  cipher_char_t cipher_exp [$];

  // traffic shaping switches, flipped per random phase
  bit idle_on;
  bit stall_on;

  int mismatches;
  int chars_checked;
  int bytes_sent;
  int key_settings;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriodNs / 2) clk = ~clk;
  end

  // hard stop in case a transfer never completes
  initial begin
    #10ms;
    $display("timeout: transfers stopped completing");
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // cipher model
  // ---------------------------------------------------------------------------

  // symbol table and its inverse; unknown bytes fall back to symbol 'a'
  function automatic void build_alphabet();
    for (int s = 0; s <= int'(SymLetterZ); s++) alphabet[s] = CharLowA + byte_t'(s);
    alphabet[SymSpace]    = CharSpace;
    alphabet[SymComma]    = CharComma;
    alphabet[SymPeriod]   = CharPeriod;
    alphabet[SymQuestion] = CharQuestion;
    alphabet[SymColon]    = CharColon;
    foreach (sym_of[b]) sym_of[b] = SymLetterA;
    for (int s = 0; s < AlphabetSize; s++) sym_of[alphabet[s]] = sym_t'(s);
    // upper case folds onto the same letters
    for (int s = 0; s <= int'(SymLetterZ); s++) sym_of[CharUpA + byte_t'(s)] = sym_t'(s);
  endfunction

  function automatic void reset_cipher_model();
    key_mat  = '{KeyR0C0Rst, KeyR0C1Rst, KeyR1C0Rst, KeyR1C1Rst};
    held_sym = SymLetterA;
    holding  = 1'b0;
  endfunction

  // first byte of a pair is held; the second yields both cipher characters
  function automatic void cipher_text_byte(byte_t b);
    sym_t        s;
    int unsigned row0;
    int unsigned row1;
    s = sym_of[b];
    if (!holding) begin
      held_sym = s;
      holding  = 1'b1;
    end else begin
      // a key of 31 needs no special handling, the mod folds it to zero
      row0 = (32'(key_mat[0]) * 32'(held_sym) + 32'(key_mat[1]) * 32'(s)) % AlphabetSize;
      row1 = (32'(key_mat[2]) * 32'(held_sym) + 32'(key_mat[3]) * 32'(s)) % AlphabetSize;
      cipher_exp.push_back('{cipher_byte: alphabet[row0], pair_last: 1'b0});
      cipher_exp.push_back('{cipher_byte: alphabet[row1], pair_last: 1'b1});
      holding = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, now and then a long one
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly alphabet characters in either case, the rest any byte at all
  function automatic byte_t random_text_byte();
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    if (r < 20) return byte_t'($urandom_range(0, 255));
    s = $urandom_range(0, AlphabetSize - 1);
    if (s <= SymLetterZ && r < 45) return CharUpA + byte_t'(s);
    return alphabet[s];
  endfunction

  // key values weighted towards 0, 30 and 31; bits above the key are junk
  function automatic cfg_data_t random_key_data();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 12) k = 0;
    else if (r < 24) k = AlphabetSize - 1;
    else if (r < 32) k = AlphabetSize;
    else k = $urandom_range(0, AlphabetSize - 1);
    return (cfg_data_t'($urandom_range(0, 7)) << KeyW) | cfg_data_t'(k);
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // valid stays high when the next byte follows without a gap
  task automatic send_text(input byte_t b);
    int unsigned gap;
    gap = idle_on ? random_gap() : 0;
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    cipher_text_byte(b);
    bytes_sent++;
  endtask

  task automatic send_pair(input byte_t first, input byte_t second);
    send_text(first);
    send_text(second);
  endtask

  // one register write; valid is left high for a following write
  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      RegKeyR0C0: key_mat[0] = val[KeyW-1:0];
      RegKeyR0C1: key_mat[1] = val[KeyW-1:0];
      RegKeyR1C0: key_mat[2] = val[KeyW-1:0];
      RegKeyR1C1: key_mat[3] = val[KeyW-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_key(input cfg_data_t k00, input cfg_data_t k01,
                             input cfg_data_t k10, input cfg_data_t k11);
    cfg_write(RegKeyR0C0, k00);
    cfg_write(RegKeyR0C1, k01);
    cfg_write(RegKeyR1C0, k10);
    cfg_write(RegKeyR1C1, k11);
    key_settings++;
  endtask

  // let every expected character out, then give the pipe time to empty
  task automatic wait_quiet();
    text_ch.valid <= 1'b0;
    while (cipher_exp.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random back-pressure and the checker
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned n;
    cipher_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    cipher_ch.ready <= 1'b1;
    forever begin
      n = $urandom_range(1, 24);
      repeat (n) @(posedge clk);
      if (stall_on) begin
        n = random_gap();
        if (n > 0) begin
          cipher_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
          cipher_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < ReportLimit) begin
      $display("%0t ns mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // each cipher transfer is matched against the oldest prediction
  always @(posedge clk) begin
    cipher_char_t want;
    if (rst_n && cipher_ch.valid && cipher_ch.ready) begin
      if (cipher_exp.size() == 0) begin
        report_mismatch("cipher transfer with nothing expected", cipher_ch.cipher_byte, 0);
      end else begin
        want = cipher_exp.pop_front();
        if (cipher_ch.cipher_byte !== want.cipher_byte) begin
          report_mismatch("cipher_byte", cipher_ch.cipher_byte, want.cipher_byte);
        end
        if (cipher_ch.pair_last !== want.pair_last) begin
          report_mismatch("pair_last", cipher_ch.pair_last, want.pair_last);
        end
        chars_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // identity key after reset: text comes back folded to lower case
  task automatic test_identity_key();
    send_pair(CharLowA, CharLowZ);
    send_pair(CharUpA, CharUpZ);
    send_pair(CharSpace, CharComma);
    send_pair(CharPeriod, CharQuestion);
    send_pair(CharColon, 8'h00);
    // bytes either side of the letter ranges are unknown and read as 'a'
    send_pair(8'hff, CharUpA - 8'd1);
    send_pair(CharUpZ + 8'd1, CharLowA - 8'd1);
    send_pair(CharLowZ + 8'd1, CharColon);
  endtask

  task automatic test_key_extremes();
    // largest reduced key with largest symbols, widest sum
    wait_quiet();
    program_key(8'h1e, 8'h1e, 8'h1e, 8'h1e);
    cfg_release();
    send_pair(CharColon, CharColon);
    // key of 31 behaves as zero, junk in the upper data bits
    wait_quiet();
    program_key(8'hff, 8'hff, 8'hff, 8'hff);
    cfg_release();
    send_pair(CharLowZ, CharUpZ);
    // all-zero key
    wait_quiet();
    program_key(8'he0, 8'he0, 8'he0, 8'he0);
    cfg_release();
    send_pair(CharColon, CharQuestion);
    // distinct entries catch swapped rows or columns
    wait_quiet();
    program_key(8'h01, 8'h02, 8'h03, 8'h04);
    cfg_release();
    send_pair(CharLowA + 8'd1, CharLowA + 8'd2);
    // writes past the last key register must leave the key alone
    wait_quiet();
    cfg_write(RegFirstUnused, 8'hff);
    cfg_write(RegLastUnused, 8'h00);
    cfg_release();
    send_pair(CharLowA + 8'd1, CharLowA + 8'd2);
  endtask

  // a lone byte stays held with no output until its partner arrives
  task automatic test_odd_length();
    wait_quiet();
    send_text(CharQuestion);
    wait_quiet();
    send_text(CharLowZ);
  endtask

  // phases cycle through idling on both sides, one side only and none
  task automatic test_random_traffic();
    for (int p = 0; p < RandomPhases; p++) begin
      idle_on  = (p % 4 == 0) || (p % 4 == 2);
      stall_on = (p % 4 == 0) || (p % 4 == 1);
      wait_quiet();
      program_key(random_key_data(), random_key_data(), random_key_data(),
                  random_key_data());
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(cfg_idx_t'($urandom_range(4, 255)), cfg_data_t'($urandom_range(0, 255)));
      end
      cfg_release();
      for (int i = 0; i < PhaseBytes; i++) send_text(random_text_byte());
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    build_alphabet();
    reset_cipher_model();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    rst_n             <= 1'b0;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_key();
    test_key_extremes();
    test_odd_length();
    test_random_traffic();

    // drain with a bound, anything still waiting afterwards is a failure
    text_ch.valid <= 1'b0;
    waited = 0;
    while (cipher_exp.size() != 0 && waited < EndWaitCycles) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (cipher_exp.size() != 0) begin
      report_mismatch("cipher characters never transferred", 0, cipher_exp.size());
    end

    $display("sent %0d text bytes, checked %0d cipher characters, %0d mismatches",
             bytes_sent, chars_checked, mismatches);
    $display("%0d key settings incl. 0, 30 and 31, unused indexes, odd tail, idle and stall",
             key_settings);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
